// File: rtl/bti_pkg.sv
// shared types and constants of the breakpoint table interpolator
package bti_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_METAL_ROWS = 8;
  localparam int TABLE_COUNT    = 3;
  localparam int FRAC_W         = 16;
  localparam int CNT_W          = $clog2(FRAC_W);
  localparam logic [6:0] POINT_COUNT_RST = 7'd64;

  localparam logic [1:0] ACT_WR_TIME  = 2'd0;
  localparam logic [1:0] ACT_WR_ENTRY = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P0CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_LAST_RD,
    S_LAST_CHK,
    S_DIV,
    S_VLO_RD,
    S_VHI_RD,
    S_MUL,
    S_SUM,
    S_DONE
  } state_t;

endpackage

// File: rtl/bti_in_if.sv
// input channel: load and query transactions
interface bti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  entry_index;
  logic [2:0]  metal_index;
  logic [1:0]  table_select;
  logic [31:0] time_value;
  logic signed [31:0] entry_value;

  modport source (output valid, action, entry_index, metal_index, table_select,
                  time_value, entry_value, input ready);
  modport sink (input valid, action, entry_index, metal_index, table_select,
                time_value, entry_value, output ready);
endinterface

// File: rtl/bti_out_if.sv
// result channel: interpolated value, bracketing indices and fraction
interface bti_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] interpolated_value;
  logic [5:0]  low_index;
  logic [5:0]  high_index;
  logic [15:0] fraction;
  logic        is_query_result;

  modport source (output valid, interpolated_value, low_index, high_index, fraction,
                  is_query_result, input ready);
  modport sink (input valid, interpolated_value, low_index, high_index, fraction,
                is_query_result, output ready);
endinterface

// File: rtl/bti_cfg_if.sv
// configuration write channel for the point count register
interface bti_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/breakpoint_table_interpolator_unit.sv
// Breakpoint table interpolator: top level with sequencer, memories and shared divider.
// Usage:
//   in_ch carries one transaction per item: action 0 writes a breakpoint time, action 1
//   writes one table entry, action 2 queries. Every transaction yields one result on
//   out_ch; loads answer with an all-zero result, queries with the interpolated value,
//   both bracketing indices and the Q0.16 fraction.
//   cfg_ch writes point_count; it is always ready and should only be written while idle.
// Sequencing:
//   one item at a time; in_ch.ready is high only while the sequencer is idle.
//   a load goes straight to its result. A query first scans the breakpoints up to the
//   bracketing low index, reading one entry at a time through the single registered
//   memory port, then a 16-step restoring divide shares one subtractor, then two table
//   reads and one multiply. A query at or below the first breakpoint skips the scan and
//   the divide.
// Reset:
//   rst_n clears the sequencer, the output valid and sets point_count to 64. The
//   breakpoint and table memories are not cleared and must be written before use.
// Stall:
//   a finished result sits in the output register; the next item is taken meanwhile, but
//   its own result waits in the final state until the output register is free.
module breakpoint_table_interpolator_unit
  import bti_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int METAL_ROWS = DEF_METAL_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  bti_in_if.sink      in_ch,
  bti_out_if.source   out_ch,
  bti_cfg_if.sink     cfg_ch
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int RW = (METAL_ROWS > 1) ? $clog2(METAL_ROWS) : 1;
  localparam int TD = TABLE_COUNT * METAL_ROWS * MAX_POINTS;
  localparam int TW = $clog2(TD);

  function automatic logic [TW-1:0] tbl_addr(input logic [31:0] sel, input logic [31:0] row,
                                             input logic [31:0] col);
    logic [31:0] a;
    a = (sel * METAL_ROWS + row) * MAX_POINTS + col;
    return a[TW-1:0];
  endfunction

  logic [31:0] bp_mem  [MAX_POINTS];
  logic [31:0] tbl_mem [TD];
  logic [31:0] bp_q_r, tbl_q_r;
  logic [PW-1:0] bp_rd_addr;
  logic [TW-1:0] tbl_rd_addr;

  state_t state_r, state_nxt;
  logic [6:0]  point_count_r;
  logic [PW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, last_r, last_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic [31:0] t_r, t_nxt, t_lo_r, t_lo_nxt, t_hi_r, t_hi_nxt;
  logic [31:0] rem_r, rem_nxt, gap_r, gap_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [31:0] vlo_r, vlo_nxt, val_r, val_nxt;
  logic signed [49:0] prod_r, prod_nxt;
  logic        query_r, query_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic [5:0]  out_lo_r, out_hi_r;
  logic [FRAC_W-1:0] out_frac_r;
  logic        out_query_r;
  logic        out_load;

  logic        in_acc;
  logic        col_ok, row_ok;
  logic [31:0] dt;
  logic [32:0] rem2;
  logic signed [32:0] diff;
  logic [34:0] sum;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign col_ok = 32'(in_ch.entry_index) < 32'(MAX_POINTS);
  assign row_ok = 32'(in_ch.metal_index) < 32'(METAL_ROWS);

  // memories: one write port driven by loads, one registered read port each
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == ACT_WR_TIME && col_ok) begin
      bp_mem[PW'(in_ch.entry_index)] <= in_ch.time_value;
    end
    if (in_acc && in_ch.action == ACT_WR_ENTRY && col_ok && row_ok &&
        32'(in_ch.table_select) < 32'(TABLE_COUNT)) begin
      tbl_mem[tbl_addr(32'(in_ch.table_select), 32'(in_ch.metal_index),
                       32'(in_ch.entry_index))] <= in_ch.entry_value;
    end
    bp_q_r  <= bp_mem[bp_rd_addr];
    tbl_q_r <= tbl_mem[tbl_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= POINT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        point_count_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    last_r <= last_nxt;
    row_r  <= row_nxt;
    sel_r  <= sel_nxt;
    t_r    <= t_nxt;
    t_lo_r <= t_lo_nxt;
    t_hi_r <= t_hi_nxt;
    rem_r  <= rem_nxt;
    gap_r  <= gap_nxt;
    cnt_r  <= cnt_nxt;
    frac_r <= frac_nxt;
    vlo_r  <= vlo_nxt;
    prod_r <= prod_nxt;
    val_r  <= val_nxt;
    query_r <= query_nxt;
    if (out_load) begin
      out_value_r <= val_r;
      out_lo_r    <= 6'(lo_r);
      out_hi_r    <= 6'(hi_r);
      out_frac_r  <= frac_r;
      out_query_r <= query_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    last_nxt  = last_r;
    row_nxt   = row_r;
    sel_nxt   = sel_r;
    t_nxt     = t_r;
    t_lo_nxt  = t_lo_r;
    t_hi_nxt  = t_hi_r;
    rem_nxt   = rem_r;
    gap_nxt   = gap_r;
    cnt_nxt   = cnt_r;
    frac_nxt  = frac_r;
    vlo_nxt   = vlo_r;
    prod_nxt  = prod_r;
    val_nxt   = val_r;
    query_nxt = query_r;
    bp_rd_addr  = '0;
    tbl_rd_addr = '0;
    out_load    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    dt   = (t_r <= bp_q_r) ? (t_r - t_lo_r) : 32'd0;
    rem2 = {rem_r, 1'b0};
    diff = $signed({tbl_q_r[31], tbl_q_r}) - $signed({vlo_r[31], vlo_r});
    sum  = {{3{vlo_r[31]}}, vlo_r} + {prod_r[49], prod_r[49:16]};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          lo_nxt    = '0;
          hi_nxt    = '0;
          frac_nxt  = '0;
          val_nxt   = '0;
          query_nxt = 1'b0;
          state_nxt = S_DONE;
          if (in_ch.action == ACT_QUERY) begin
            query_nxt = 1'b1;
            t_nxt     = in_ch.time_value;
            sel_nxt   = in_ch.table_select;
            row_nxt   = row_ok ? RW'(in_ch.metal_index) : RW'(METAL_ROWS - 1);
            // zero count acts as one point, large counts clamp to the table depth
            if (point_count_r == 7'd0) begin
              last_nxt = '0;
            end else if (32'(point_count_r) >= 32'(MAX_POINTS)) begin
              last_nxt = PW'(MAX_POINTS - 1);
            end else begin
              last_nxt = PW'(32'(point_count_r) - 32'd1);
            end
            state_nxt = S_P0CHK;
          end
        end
      end
      S_P0CHK: begin
        if (t_r <= bp_q_r) begin
          state_nxt = S_VLO_RD;
        end else begin
          t_lo_nxt  = bp_q_r;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (lo_r == last_r) begin
          hi_nxt    = lo_r;
          t_hi_nxt  = t_lo_r;
          state_nxt = S_LAST_RD;
        end else begin
          bp_rd_addr = lo_r + PW'(1);
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (t_r > bp_q_r) begin
          lo_nxt    = lo_r + PW'(1);
          t_lo_nxt  = bp_q_r;
          state_nxt = S_SCAN_RD;
        end else begin
          hi_nxt    = lo_r + PW'(1);
          t_hi_nxt  = bp_q_r;
          state_nxt = S_LAST_RD;
        end
      end
      S_LAST_RD: begin
        bp_rd_addr = last_r;
        state_nxt  = S_LAST_CHK;
      end
      S_LAST_CHK: begin
        state_nxt = S_VLO_RD;
        if (t_hi_r > t_lo_r) begin
          gap_nxt = t_hi_r - t_lo_r;
          if (dt >= gap_nxt) begin
            frac_nxt = '1;
          end else begin
            rem_nxt   = dt;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem2 >= {1'b0, gap_r}) begin
          rem_nxt  = 32'(rem2 - {1'b0, gap_r});
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem2[31:0];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_W - 1)) begin
          state_nxt = S_VLO_RD;
        end
      end
      S_VLO_RD: begin
        if (32'(sel_r) < 32'(TABLE_COUNT)) begin
          tbl_rd_addr = tbl_addr(32'(sel_r), 32'(row_r), 32'(lo_r));
          state_nxt   = S_VHI_RD;
        end else begin
          val_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_VHI_RD: begin
        tbl_rd_addr = tbl_addr(32'(sel_r), 32'(row_r), 32'(hi_r));
        vlo_nxt     = tbl_q_r;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = 50'(diff) * 50'($signed({1'b0, frac_r}));
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // arithmetic shift gives the floor, then clamp to the signed range
        if (!sum[34] && sum[33:31] != 3'b000) begin
          val_nxt = 32'h7FFF_FFFF;
        end else if (sum[34] && sum[33:31] != 3'b111) begin
          val_nxt = 32'h8000_0000;
        end else begin
          val_nxt = sum[31:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.interpolated_value = out_value_r;
  assign out_ch.low_index          = out_lo_r;
  assign out_ch.high_index         = out_hi_r;
  assign out_ch.fraction           = out_frac_r;
  assign out_ch.is_query_result    = out_query_r;

  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.action == ACT_QUERY) |=> state_r == S_P0CHK)
    else $error("query transaction did not start the breakpoint scan");

  a_load_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_query_r) |-> (out_value_r == 32'd0 && out_frac_r == '0 &&
                                       out_lo_r == 6'd0 && out_hi_r == 6'd0))
    else $error("load acknowledge carries nonzero fields");

  a_div_rem_below_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> rem_r < gap_r)
    else $error("divider remainder not below the gap");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD || state_r == S_SCAN_CHK) |-> lo_r <= last_r)
    else $error("scan index ran past the last breakpoint");

endmodule
